FILE: src/sfp_pkg.sv
// Shared types, constants and helpers of the snapshot frame parser.
`timescale 1ns / 1ps

package sfp_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_Q = 8'h51;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_S = 8'h53;

    localparam logic [31:0] NEED_Q = 32'd10;
    localparam logic [31:0] NEED_F = 32'd3;
    localparam int          NEED_S_BASE = 14;

    localparam logic [3:0] LEN_BYTES   = 4'd4;
    localparam logic [3:0] LOC_BYTES   = 4'd2;
    localparam logic [3:0] SEQ_BYTES   = 4'd8;
    localparam logic [3:0] WORD_BYTES  = 4'd4;
    localparam logic [3:0] ONE_BYTE    = 4'd1;

    typedef enum logic [3:0] {
        PH_LEN,
        PH_OPCODE,
        PH_LOCATE,
        PH_SEQ,
        PH_SYMBOL,
        PH_BIDCNT,
        PH_BIDLVL,
        PH_ASKCNT,
        PH_ASKLVL,
        PH_FCODE,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        OPC_Q,
        OPC_F,
        OPC_S
    } t_opc;

    typedef enum logic [2:0] {
        K_REQUEST,
        K_FAULT,
        K_HEADER,
        K_BID,
        K_ASKCNT,
        K_ASK,
        K_END,
        K_REJECT
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SHORT,
        ST_OPCODE,
        ST_OVERRUN
    } t_status;

    typedef struct packed {
        t_kind        record_kind;
        logic [15:0]  locate;
        logic [63:0]  sequence_res;
        logic [63:0]  symbol;
        logic [31:0]  level_count;
        logic [7:0]   fault_code;
        logic [31:0]  price;
        logic [31:0]  quantity;
        logic [31:0]  orders;
        t_status      status;
    } t_rec;

    typedef struct packed {
        logic [1:0] cnt;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              no_room;
    } t_qstat;

    function automatic t_rec make_rec(input t_kind kind, input logic [15:0] loc);
        t_rec r;
        r = '0;
        r.record_kind = kind;
        r.locate = (kind == K_REJECT) ? 16'd0 : loc;
        return r;
    endfunction

endpackage

FILE: src/sfp_parse.sv
// Byte-serial frame parser: field assembler, counters and record generation.
`timescale 1ns / 1ps

module sfp_parse
    import sfp_pkg::*;
#(
    parameter int SYMBOL_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    output t_push      o_push
);

    localparam logic [31:0] NEED_S  = 32'(NEED_S_BASE + SYMBOL_BYTES);
    localparam logic [3:0]  SYM_LEN = 4'(SYMBOL_BYTES);

    t_phase      r_phase, n_phase;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [3:0]  r_idx, n_idx;
    t_opc        r_opc, n_opc;
    logic [63:0] r_shift, n_shift;
    logic [15:0] r_locate, n_locate;
    logic [63:0] r_seq, n_seq;
    logic [63:0] r_symbol, n_symbol;
    logic [31:0] r_levels_left, n_levels_left;
    logic [1:0]  r_lvl_idx, n_lvl_idx;
    logic [31:0] r_price, n_price;
    logic [31:0] r_qty, n_qty;
    t_status     r_frame_status, n_frame_status;

    logic [63:0] g_shift;
    logic [3:0]  g_idx;
    logic [3:0]  g_nbytes;
    logic        g_done;
    logic [31:0] g_word;
    logic [31:0] dec;
    logic        bid_over;
    logic        ask_over;
    logic        lvl_last;
    logic        lvl_emit;
    logic        op_known;
    logic        op_short;
    t_opc        op_code;
    logic        gathering;

    assign g_shift  = {r_shift[55:0], i_data_byte};
    assign g_idx    = r_idx + 4'd1;
    assign g_done   = g_idx >= g_nbytes;
    assign g_word   = g_shift[31:0];
    assign dec      = r_bytes_left - 32'd1;
    assign bid_over = (({4'b0, g_word} * 36'd12) + 36'd4) > {4'b0, dec};
    assign ask_over = ({4'b0, g_word} * 36'd12) > {4'b0, dec};
    assign lvl_last = r_levels_left == 32'd1;
    assign lvl_emit = r_lvl_idx >= 2'd2;
    assign gathering = r_phase inside {PH_LOCATE, PH_SEQ, PH_SYMBOL, PH_BIDCNT,
                                       PH_BIDLVL, PH_ASKCNT, PH_ASKLVL};

    always_comb begin
        case (r_phase)
            PH_LEN:    g_nbytes = LEN_BYTES;
            PH_LOCATE: g_nbytes = LOC_BYTES;
            PH_SEQ:    g_nbytes = SEQ_BYTES;
            PH_SYMBOL: g_nbytes = SYM_LEN;
            PH_BIDCNT, PH_BIDLVL, PH_ASKCNT, PH_ASKLVL: g_nbytes = WORD_BYTES;
            default:   g_nbytes = ONE_BYTE;
        endcase
    end

    always_comb begin
        op_known = 1'b1;
        op_short = 1'b0;
        op_code  = OPC_Q;
        case (i_data_byte)
            CH_Q: begin
                op_code  = OPC_Q;
                op_short = dec < NEED_Q;
            end
            CH_F: begin
                op_code  = OPC_F;
                op_short = dec < NEED_F;
            end
            CH_S: begin
                op_code  = OPC_S;
                op_short = dec < NEED_S;
            end
            default: begin
                op_known = 1'b0;
            end
        endcase
    end

    // Next-state logic.
    always_comb begin
        n_phase        = r_phase;
        n_bytes_left   = r_bytes_left;
        n_idx          = r_idx;
        n_opc          = r_opc;
        n_shift        = r_shift;
        n_locate       = r_locate;
        n_seq          = r_seq;
        n_symbol       = r_symbol;
        n_levels_left  = r_levels_left;
        n_lvl_idx      = r_lvl_idx;
        n_price        = r_price;
        n_qty          = r_qty;
        n_frame_status = r_frame_status;
        if (i_accept) begin
            if (r_phase == PH_LEN) begin
                n_shift = g_done ? 64'd0 : g_shift;
                n_idx   = g_done ? 4'd0 : g_idx;
                if (g_done) begin
                    n_bytes_left = g_word;
                    if (g_word != 32'd0) begin
                        n_phase = PH_OPCODE;
                    end
                end
            end else begin
                n_bytes_left = dec;
                if (gathering) begin
                    n_shift = g_done ? 64'd0 : g_shift;
                    n_idx   = g_done ? 4'd0 : g_idx;
                end
                case (r_phase)
                    PH_OPCODE: begin
                        n_frame_status = ST_OK;
                        n_locate       = 16'd0;
                        n_seq          = 64'd0;
                        n_symbol       = 64'd0;
                        n_levels_left  = 32'd0;
                        n_lvl_idx      = 2'd0;
                        n_idx          = 4'd0;
                        n_shift        = 64'd0;
                        if (op_known) begin
                            n_opc = op_code;
                        end
                        n_phase = (!op_known || op_short) ? PH_SKIP : PH_LOCATE;
                    end
                    PH_LOCATE: begin
                        if (g_done) begin
                            n_locate = g_shift[15:0];
                            n_phase  = (r_opc == OPC_F) ? PH_FCODE : PH_SEQ;
                        end
                    end
                    PH_FCODE: begin
                        n_phase = PH_SKIP;
                    end
                    PH_SEQ: begin
                        if (g_done) begin
                            n_seq   = g_shift;
                            n_phase = (r_opc == OPC_Q) ? PH_SKIP : PH_SYMBOL;
                        end
                    end
                    PH_SYMBOL: begin
                        if (g_done) begin
                            n_symbol = g_shift;
                            n_phase  = PH_BIDCNT;
                        end
                    end
                    PH_BIDCNT: begin
                        if (g_done) begin
                            if (bid_over) begin
                                n_frame_status = ST_OVERRUN;
                                n_phase        = PH_SKIP;
                            end else begin
                                n_levels_left = g_word;
                                n_lvl_idx     = 2'd0;
                                n_phase       = (g_word != 32'd0) ? PH_BIDLVL : PH_ASKCNT;
                            end
                        end
                    end
                    PH_ASKCNT: begin
                        if (g_done) begin
                            if (ask_over) begin
                                n_frame_status = ST_OVERRUN;
                                n_phase        = PH_SKIP;
                            end else if (g_word == 32'd0) begin
                                n_phase = PH_SKIP;
                            end else begin
                                n_levels_left = g_word;
                                n_lvl_idx     = 2'd0;
                                n_phase       = PH_ASKLVL;
                            end
                        end
                    end
                    PH_BIDLVL, PH_ASKLVL: begin
                        if (g_done) begin
                            case (r_lvl_idx)
                                2'd0: begin
                                    n_price   = g_word;
                                    n_lvl_idx = 2'd1;
                                end
                                2'd1: begin
                                    n_qty     = g_word;
                                    n_lvl_idx = 2'd2;
                                end
                                default: begin
                                    n_lvl_idx     = 2'd0;
                                    n_levels_left = r_levels_left - 32'd1;
                                    if (lvl_last) begin
                                        n_phase = (r_phase == PH_ASKLVL) ? PH_SKIP : PH_ASKCNT;
                                    end
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_phase = PH_SKIP;
                    end
                endcase
                if (dec == 32'd0) begin
                    n_phase = PH_LEN;
                    n_idx   = 4'd0;
                    n_shift = 64'd0;
                end
            end
        end
    end

    // Record generation.
    always_comb begin
        o_push = '0;
        if (i_accept) begin
            case (r_phase)
                PH_LEN: begin
                    if (g_done && g_word == 32'd0) begin
                        o_push.cnt         = 2'd1;
                        o_push.rec0        = make_rec(K_REJECT, r_locate);
                        o_push.rec0.status = ST_SHORT;
                    end
                end
                PH_OPCODE: begin
                    if (!op_known || op_short) begin
                        o_push.cnt         = 2'd1;
                        o_push.rec0        = make_rec(K_REJECT, r_locate);
                        o_push.rec0.status = op_known ? ST_SHORT : ST_OPCODE;
                    end
                end
                PH_FCODE: begin
                    o_push.cnt             = 2'd1;
                    o_push.rec0            = make_rec(K_FAULT, r_locate);
                    o_push.rec0.fault_code = i_data_byte;
                end
                PH_SEQ: begin
                    if (g_done && r_opc == OPC_Q) begin
                        o_push.cnt               = 2'd1;
                        o_push.rec0              = make_rec(K_REQUEST, r_locate);
                        o_push.rec0.sequence_res = g_shift;
                    end
                end
                PH_BIDCNT: begin
                    if (g_done) begin
                        o_push.cnt               = 2'd1;
                        o_push.rec0              = make_rec(K_HEADER, r_locate);
                        o_push.rec0.sequence_res = r_seq;
                        o_push.rec0.symbol       = r_symbol;
                        o_push.rec0.level_count  = g_word;
                        if (bid_over) begin
                            o_push.cnt         = 2'd2;
                            o_push.rec1        = make_rec(K_END, r_locate);
                            o_push.rec1.status = ST_OVERRUN;
                        end
                    end
                end
                PH_ASKCNT: begin
                    if (g_done) begin
                        o_push.cnt              = 2'd1;
                        o_push.rec0             = make_rec(K_ASKCNT, r_locate);
                        o_push.rec0.level_count = g_word;
                        if (ask_over || g_word == 32'd0) begin
                            o_push.cnt         = 2'd2;
                            o_push.rec1        = make_rec(K_END, r_locate);
                            o_push.rec1.status = ask_over ? ST_OVERRUN : r_frame_status;
                        end
                    end
                end
                PH_BIDLVL, PH_ASKLVL: begin
                    if (g_done && lvl_emit) begin
                        o_push.cnt  = 2'd1;
                        o_push.rec0 = make_rec((r_phase == PH_ASKLVL) ? K_ASK : K_BID,
                                               r_locate);
                        o_push.rec0.price    = r_price;
                        o_push.rec0.quantity = r_qty;
                        o_push.rec0.orders   = g_word;
                        if (lvl_last && r_phase == PH_ASKLVL) begin
                            o_push.cnt         = 2'd2;
                            o_push.rec1        = make_rec(K_END, r_locate);
                            o_push.rec1.status = r_frame_status;
                        end
                    end
                end
                default: begin
                    o_push = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_LEN;
            r_bytes_left   <= 32'd0;
            r_idx          <= 4'd0;
            r_opc          <= OPC_Q;
            r_shift        <= 64'd0;
            r_locate       <= 16'd0;
            r_seq          <= 64'd0;
            r_symbol       <= 64'd0;
            r_levels_left  <= 32'd0;
            r_lvl_idx      <= 2'd0;
            r_price        <= 32'd0;
            r_qty          <= 32'd0;
            r_frame_status <= ST_OK;
        end else begin
            r_phase        <= n_phase;
            r_bytes_left   <= n_bytes_left;
            r_idx          <= n_idx;
            r_opc          <= n_opc;
            r_shift        <= n_shift;
            r_locate       <= n_locate;
            r_seq          <= n_seq;
            r_symbol       <= n_symbol;
            r_levels_left  <= n_levels_left;
            r_lvl_idx      <= n_lvl_idx;
            r_price        <= n_price;
            r_qty          <= n_qty;
            r_frame_status <= n_frame_status;
        end
    end

endmodule

FILE: src/sfp_outq.sv
// Result queue that takes up to two records per cycle and releases one.
`timescale 1ns / 1ps

module sfp_outq
    import sfp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_rec   o_head,
    output t_qstat o_stat
);

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic              pop_ok;

    assign pop_ok      = i_pop && (r_count != '0);
    assign wr_ptr_next = r_wr_ptr + QPTR_W'(1);
    assign n_wr_ptr    = r_wr_ptr + QPTR_W'(i_push.cnt);
    assign n_rd_ptr    = r_rd_ptr + QPTR_W'(pop_ok);
    assign n_count     = r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop_ok);

    assign o_head         = r_mem[r_rd_ptr];
    assign o_stat.count   = r_count;
    assign o_stat.no_room = r_count > QCNT_W'(QDEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.rec0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: src/snapshot_frame_parser.sv
// Top level of the snapshot frame parser: byte parser feeding a result queue.
//
// Channel   Dir   Handshake           Payload
// input     in    i_valid / o_stall   i_data_byte
// output    out   o_valid / i_stall   o_record_kind .. o_status
//
// One byte is accepted per cycle while o_stall is low; its parsing finishes in
// that cycle. Its records are written into a four-entry queue driving the outputs;
// a byte makes up to two records, and one leaves per cycle while i_stall is low.
// The input stalls while the queue has fewer than two free entries.
// Synchronous reset returns the parser to waiting for a length and empties the queue.
`timescale 1ns / 1ps

module snapshot_frame_parser
    import sfp_pkg::*;
#(
    parameter int SYMBOL_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_record_kind,
    output logic [15:0] o_locate,
    output logic [63:0] o_sequence_res,
    output logic [63:0] o_symbol,
    output logic [31:0] o_level_count,
    output logic [7:0]  o_fault_code,
    output logic [31:0] o_price,
    output logic [31:0] o_quantity,
    output logic [31:0] o_orders,
    output logic [1:0]  o_status
);

    logic   in_acc;
    t_push  push;
    t_rec   head;
    t_qstat qstat;

    assign o_stall = qstat.no_room;
    assign in_acc  = i_valid && !qstat.no_room;
    assign o_valid = qstat.count != '0;

    sfp_parse #(
        .SYMBOL_BYTES(SYMBOL_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_data_byte (i_data_byte),
        .o_push      (push)
    );

    sfp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_head  (head),
        .o_stat  (qstat)
    );

    assign o_record_kind  = head.record_kind;
    assign o_locate       = head.locate;
    assign o_sequence_res = head.sequence_res;
    assign o_symbol       = head.symbol;
    assign o_level_count  = head.level_count;
    assign o_fault_code   = head.fault_code;
    assign o_price        = head.price;
    assign o_quantity     = head.quantity;
    assign o_orders       = head.orders;
    assign o_status       = head.status;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= QCNT_W'(QDEPTH))
        else $error("Result queue holds more entries than its depth.");

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0) |-> in_acc)
        else $error("Records were produced without an accepted transaction.");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_acc && qstat.count == '0) |=> !o_valid)
        else $error("A result appeared with no transaction to cause it.");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt == 2'd2) |-> (qstat.count <= QCNT_W'(QDEPTH - 2)))
        else $error("Two records were pushed without room for both.");

endmodule

FILE: bench/tb.sv
// Self-checking testbench of the snapshot frame parser with a record predictor.
`timescale 1ns / 1ps

module tb;
    import sfp_pkg::*;

    localparam int SYM_BYTES = 8;
    localparam logic [31:0] REQ_BODY = 32'd10;
    localparam logic [31:0] FAULT_BODY = 32'd3;
    localparam logic [31:0] SNAP_FIXED = 32'd14;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS = 30;
    localparam int IDLE_PCT = 28;
    localparam int LV_RAND = 0;
    localparam int LV_ONES = 1;
    localparam int LV_ZERO = 2;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_record_kind;
    logic [15:0] o_locate;
    logic [63:0] o_sequence_res;
    logic [63:0] o_symbol;
    logic [31:0] o_level_count;
    logic [7:0]  o_fault_code;
    logic [31:0] o_price;
    logic [31:0] o_quantity;
    logic [31:0] o_orders;
    logic [1:0]  o_status;

    snapshot_frame_parser #(.SYMBOL_BYTES(SYM_BYTES)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_record_kind  (o_record_kind),
        .o_locate       (o_locate),
        .o_sequence_res (o_sequence_res),
        .o_symbol       (o_symbol),
        .o_level_count  (o_level_count),
        .o_fault_code   (o_fault_code),
        .o_price        (o_price),
        .o_quantity     (o_quantity),
        .o_orders       (o_orders),
        .o_status       (o_status)
    );

    // Predictor state of the parser.
    t_phase      ph;
    logic [31:0] left;
    logic [3:0]  fidx;
    t_opc        opc;
    logic [63:0] fsh;
    logic [15:0] loc_h;
    logic [63:0] seq_h;
    logic [63:0] sym_h;
    logic [31:0] lv_left;
    logic [1:0]  lw_idx;
    logic [31:0] pr_h;
    logic [31:0] qt_h;
    t_status     fst;

    t_rec        pending_records[$];
    t_rec        want;
    logic [7:0]  frame_q[$];

    int n_errors = 0;
    int n_checked = 0;
    int n_frames = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;
    int hold_req = 0;
    int hold_left = 0;
    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic reset_model();
        ph = PH_LEN;
        left = '0;
        fidx = '0;
        opc = OPC_Q;
        fsh = '0;
        loc_h = '0;
        seq_h = '0;
        sym_h = '0;
        lv_left = '0;
        lw_idx = '0;
        pr_h = '0;
        qt_h = '0;
        fst = ST_OK;
    endtask

    function automatic bit gather(input logic [7:0] b, input logic [3:0] n,
                                  output logic [63:0] v);
        fsh = {fsh[55:0], b};
        fidx = fidx + 4'd1;
        v = fsh;
        if (fidx >= n) begin
            fsh = '0;
            fidx = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_rec blank_rec(input t_kind k);
        t_rec r;
        r = '0;
        r.record_kind = k;
        if (k != K_REJECT) r.locate = loc_h;
        return r;
    endfunction

    task automatic add_expected(input t_rec r);
        pending_records.insert(pending_records.size(), r);
    endtask

    task automatic reject_frame(input t_status st);
        t_rec r;
        r = blank_rec(K_REJECT);
        r.status = st;
        add_expected(r);
    endtask

    task automatic close_snapshot();
        t_rec r;
        r = blank_rec(K_END);
        r.status = fst;
        add_expected(r);
        ph = PH_SKIP;
    endtask

    task automatic take_level(input logic [31:0] w, input bit ask);
        t_rec r;
        if (lw_idx == 2'd0) begin
            pr_h = w;
            lw_idx = 2'd1;
        end else if (lw_idx == 2'd1) begin
            qt_h = w;
            lw_idx = 2'd2;
        end else begin
            lw_idx = 2'd0;
            r = blank_rec(ask ? K_ASK : K_BID);
            r.price = pr_h;
            r.quantity = qt_h;
            r.orders = w;
            add_expected(r);
            lv_left = lv_left - 32'd1;
            if (lv_left == 32'd0) begin
                if (ask) close_snapshot();
                else ph = PH_ASKCNT;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [63:0] v;
        logic [31:0] cnt;
        logic [31:0] need;
        logic [63:0] span;
        bit          known;
        t_rec        r;
        if (ph == PH_LEN) begin
            if (gather(b, LEN_BYTES, v)) begin
                left = v[31:0];
                if (left == 32'd0) reject_frame(ST_SHORT);
                else ph = PH_OPCODE;
            end
        end else begin
            left = left - 32'd1;
            case (ph)
                PH_OPCODE: begin
                    fst = ST_OK;
                    loc_h = '0;
                    seq_h = '0;
                    sym_h = '0;
                    lv_left = '0;
                    lw_idx = '0;
                    fidx = '0;
                    fsh = '0;
                    known = 1'b1;
                    need = '0;
                    if (b == CH_Q) begin
                        opc = OPC_Q;
                        need = REQ_BODY;
                    end else if (b == CH_F) begin
                        opc = OPC_F;
                        need = FAULT_BODY;
                    end else if (b == CH_S) begin
                        opc = OPC_S;
                        need = SNAP_FIXED + SYM_BYTES;
                    end else begin
                        known = 1'b0;
                    end
                    if (!known) begin
                        reject_frame(ST_OPCODE);
                        ph = PH_SKIP;
                    end else if (left < need) begin
                        reject_frame(ST_SHORT);
                        ph = PH_SKIP;
                    end else begin
                        ph = PH_LOCATE;
                    end
                end
                PH_LOCATE: begin
                    if (gather(b, LOC_BYTES, v)) begin
                        loc_h = v[15:0];
                        ph = (opc == OPC_F) ? PH_FCODE : PH_SEQ;
                    end
                end
                PH_FCODE: begin
                    r = blank_rec(K_FAULT);
                    r.fault_code = b;
                    add_expected(r);
                    ph = PH_SKIP;
                end
                PH_SEQ: begin
                    if (gather(b, SEQ_BYTES, v)) begin
                        seq_h = v;
                        if (opc == OPC_Q) begin
                            r = blank_rec(K_REQUEST);
                            r.sequence_res = v;
                            add_expected(r);
                            ph = PH_SKIP;
                        end else begin
                            ph = PH_SYMBOL;
                        end
                    end
                end
                PH_SYMBOL: begin
                    if (gather(b, 4'(SYM_BYTES), v)) begin
                        sym_h = v;
                        ph = PH_BIDCNT;
                    end
                end
                PH_BIDCNT: begin
                    if (gather(b, WORD_BYTES, v)) begin
                        cnt = v[31:0];
                        r = blank_rec(K_HEADER);
                        r.sequence_res = seq_h;
                        r.symbol = sym_h;
                        r.level_count = cnt;
                        add_expected(r);
                        span = {32'd0, cnt} * 64'd12 + 64'd4;
                        if (span > {32'd0, left}) begin
                            fst = ST_OVERRUN;
                            close_snapshot();
                        end else begin
                            lv_left = cnt;
                            lw_idx = '0;
                            ph = (cnt != 32'd0) ? PH_BIDLVL : PH_ASKCNT;
                        end
                    end
                end
                PH_BIDLVL: begin
                    if (gather(b, WORD_BYTES, v)) take_level(v[31:0], 1'b0);
                end
                PH_ASKCNT: begin
                    if (gather(b, WORD_BYTES, v)) begin
                        cnt = v[31:0];
                        r = blank_rec(K_ASKCNT);
                        r.level_count = cnt;
                        add_expected(r);
                        span = {32'd0, cnt} * 64'd12;
                        if (span > {32'd0, left}) begin
                            fst = ST_OVERRUN;
                            close_snapshot();
                        end else if (cnt == 32'd0) begin
                            close_snapshot();
                        end else begin
                            lv_left = cnt;
                            lw_idx = '0;
                            ph = PH_ASKLVL;
                        end
                    end
                end
                PH_ASKLVL: begin
                    if (gather(b, WORD_BYTES, v)) take_level(v[31:0], 1'b1);
                end
                default: begin
                    ph = PH_SKIP;
                end
            endcase
            if (left == 32'd0) begin
                ph = PH_LEN;
                fidx = '0;
                fsh = '0;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_dword();
        return {rand_word(), rand_word()};
    endfunction

    function automatic logic [15:0] rand_loc();
        logic [31:0] w;
        w = rand_word();
        return w[15:0];
    endfunction

    function automatic int trailing();
        if ($urandom_range(9) < 7) return 0;
        return $urandom_range(4, 1);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endtask

    task automatic add_be(input logic [63:0] v, input int n);
        int i;
        for (i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
    endtask

    task automatic add_random(input int n);
        int i;
        for (i = 0; i < n; i++) add_byte(8'($urandom));
    endtask

    task automatic add_level(input int mode);
        int i;
        for (i = 0; i < 3; i++) begin
            if (mode == LV_ONES) add_be(64'hFFFF_FFFF, 4);
            else if (mode == LV_ZERO) add_be(64'h0, 4);
            else add_be({32'd0, rand_word()}, 4);
        end
    endtask

    task automatic send_frame();
        logic [31:0] len;
        int i;
        len = frame_q.size();
        for (i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
        for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i]);
        frame_q.delete();
        n_frames++;
    endtask

    task automatic put_request(input logic [15:0] loc, input logic [63:0] seq, input int extra);
        add_byte(CH_Q);
        add_be({48'd0, loc}, 2);
        add_be(seq, 8);
        add_random(extra);
        send_frame();
    endtask

    task automatic put_fault(input logic [15:0] loc, input logic [7:0] code, input int extra);
        add_byte(CH_F);
        add_be({48'd0, loc}, 2);
        add_byte(code);
        add_random(extra);
        send_frame();
    endtask

    task automatic put_snapshot(input logic [15:0] loc, input logic [63:0] seq,
                                input logic [63:0] sym, input logic [31:0] bid_decl,
                                input int bid_real, input logic [31:0] ask_decl,
                                input int ask_real, input int extra, input int mode);
        int i;
        add_byte(CH_S);
        add_be({48'd0, loc}, 2);
        add_be(seq, 8);
        add_be(sym, SYM_BYTES);
        add_be({32'd0, bid_decl}, 4);
        for (i = 0; i < bid_real; i++) add_level(mode);
        add_be({32'd0, ask_decl}, 4);
        for (i = 0; i < ask_real; i++) add_level(mode);
        add_random(extra);
        send_frame();
    endtask

    task automatic put_raw(input logic [7:0] op, input int nbody);
        add_byte(op);
        add_random(nbody);
        send_frame();
    endtask

    task automatic send_random_frame();
        int pick;
        int nb;
        int na;
        logic [7:0] op;
        pick = $urandom_range(99);
        nb = $urandom_range(3);
        na = $urandom_range(3);
        if (pick < 20) begin
            put_request(rand_loc(), rand_dword(), trailing());
        end else if (pick < 35) begin
            put_fault(rand_loc(), 8'($urandom), trailing());
        end else if (pick < 75) begin
            put_snapshot(rand_loc(), rand_dword(), rand_dword(), nb, nb, na, na,
                         trailing(), LV_RAND);
        end else if (pick < 82) begin
            if ($urandom_range(1))
                put_snapshot(rand_loc(), rand_dword(), rand_dword(),
                             $urandom_range(1) ? $urandom : nb + na + 1 + $urandom_range(3),
                             nb, na, na, 0, LV_RAND);
            else
                put_snapshot(rand_loc(), rand_dword(), rand_dword(), nb, nb,
                             $urandom_range(1) ? $urandom : na + 1 + $urandom_range(3),
                             na, 0, LV_RAND);
        end else if (pick < 87) begin
            put_snapshot(rand_loc(), rand_dword(), rand_dword(), $urandom_range(4), nb,
                         $urandom_range(4), na, trailing(), LV_RAND);
        end else if (pick < 92) begin
            case ($urandom_range(2))
                0: put_raw(CH_Q, $urandom_range(REQ_BODY - 1));
                1: put_raw(CH_F, $urandom_range(FAULT_BODY - 1));
                default: put_raw(CH_S, $urandom_range(SNAP_FIXED + SYM_BYTES - 1));
            endcase
        end else if (pick < 96) begin
            op = 8'($urandom);
            while (op == CH_Q || op == CH_F || op == CH_S) op = 8'($urandom);
            put_raw(op, $urandom_range(6));
        end else begin
            send_frame();
        end
    endtask

    task automatic test_requests();
        put_request(16'h0000, 64'h0, 0);
        put_request(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        put_request(16'h5A3C, 64'h0123_4567_89AB_CDEF, 3);
    endtask

    task automatic test_faults();
        put_fault(16'h0000, 8'h00, 0);
        put_fault(16'hFFFF, 8'hFF, 2);
    endtask

    task automatic test_snapshots();
        put_snapshot(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     1, 1, 1, 1, 0, LV_ONES);
        put_snapshot(16'h0000, 64'h0, 64'h0, 1, 1, 1, 1, 0, LV_ZERO);
        put_snapshot(16'h0102, 64'h10, 64'h4142_4344_2020_2020, 0, 0, 0, 0, 0, LV_RAND);
        put_snapshot(16'h0203, 64'h20, 64'h5859_5A20_2020_2020, 2, 2, 0, 0, 3, LV_RAND);
        put_snapshot(16'h0304, 64'h30, 64'h4D4E_4F20_2020_2020, 0, 0, 2, 2, 0, LV_RAND);
    endtask

    task automatic test_overruns();
        put_snapshot(16'h1111, 64'h1, 64'h1, 32'hFFFF_FFFF, 0, 0, 0, 0, LV_RAND);
        put_snapshot(16'h2222, 64'h2, 64'h2, 2, 1, 0, 0, 0, LV_RAND);
        put_snapshot(16'h3333, 64'h3, 64'h3, 1, 1, 32'hFFFF_FFFF, 0, 0, LV_RAND);
        put_snapshot(16'h4444, 64'h4, 64'h4, 0, 0, 2, 1, 0, LV_RAND);
        put_raw(CH_S, SNAP_FIXED + SYM_BYTES);
    endtask

    task automatic test_rejects();
        send_frame();
        put_raw(8'h00, 2);
        put_raw(8'hFF, 0);
        put_raw(CH_Q, REQ_BODY - 1);
        put_raw(CH_F, FAULT_BODY - 1);
        put_raw(CH_S, SNAP_FIXED + SYM_BYTES - 1);
        put_raw(CH_Q, 0);
    endtask

    task automatic test_back_pressure();
        hold_req = 80;
        put_snapshot(16'h7777, 64'h77, 64'h77, 3, 3, 3, 3, 0, LV_RAND);
        put_request(16'h7778, 64'h78, 0);
        wait_drain();
        put_fault(16'h7779, 8'h79, 0);
        wait_drain();
    endtask

    task automatic test_calm_stream();
        int stop_at;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        stop_at = bytes_sent + 40;
        while (bytes_sent < stop_at) send_random_frame();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_random_stream();
        int stop_at;
        stop_at = bytes_sent + 80;
        while (bytes_sent < stop_at) send_random_frame();
    endtask

    task automatic check_field(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what,
                         exp_v, act_v);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= sink_idle_en && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_records.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected record, expected none, actual kind %0d",
                             $time, o_record_kind);
            end else begin
                want = pending_records.pop_front();
                n_checked++;
                check_field("record_kind", 64'(want.record_kind), 64'(o_record_kind));
                check_field("locate", 64'(want.locate), 64'(o_locate));
                check_field("sequence_res", want.sequence_res, o_sequence_res);
                check_field("symbol", want.symbol, o_symbol);
                check_field("level_count", 64'(want.level_count), 64'(o_level_count));
                check_field("fault_code", 64'(want.fault_code), 64'(o_fault_code));
                check_field("price", 64'(want.price), 64'(o_price));
                check_field("quantity", 64'(want.quantity), 64'(o_quantity));
                check_field("orders", 64'(want.orders), 64'(o_orders));
                check_field("status", 64'(want.status), 64'(o_status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no transaction for %0d cycles", $time,
                     quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = 8'h00;
        i_stall = 1'b0;
        reset_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_requests();
        test_faults();
        test_snapshots();
        test_overruns();
        test_rejects();
        test_back_pressure();
        test_calm_stream();
        test_random_stream();

        wait_drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d frames in %0d bytes: requests, faults, snapshots, rejects, overruns.",
                 n_frames, bytes_sent);
        $display("Checked %0d records with random idling and a long output hold; %0d errors.",
                 n_checked, n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/sfp_pkg.sv
src/sfp_parse.sv
src/sfp_outq.sv
src/snapshot_frame_parser.sv
bench/tb.sv
